// ===== rtl/fpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpcc_pkg
// Shared types and constants for the FP compare-condition unit.
// ----------------------------------------------------------------------------
package fpcc_pkg;

  localparam int unsigned OperandWidth = 64;
  localparam int unsigned CondWidth    = 4;

  typedef enum logic [2:0] {
    COND_F   = 3'd0,
    COND_UN  = 3'd1,
    COND_EQ  = 3'd2,
    COND_UEQ = 3'd3,
    COND_OLT = 3'd4,
    COND_ULT = 3'd5,
    COND_OLE = 3'd6,
    COND_ULE = 3'd7
  } cond_base_e;

  typedef logic [OperandWidth-1:0] operand_t;
  typedef logic [CondWidth-1:0]    cond_t;

endpackage

// ===== rtl/fp_compare_condition_unit.sv =====
// ----------------------------------------------------------------------------
// fp_compare_condition_unit
// Single/double IEEE-754 compare producing the coprocessor condition bit,
// with invalid/exception signaling for codes 8..15 on NaN.
// ----------------------------------------------------------------------------
//  channel | signals                                         | direction
//  in      | in_valid_i, in_stall_o, operand_a/b, is_double, | into block
//          | condition                                       |
//  out     | out_valid_o, out_stall_i, compare_bit,          | out of block
//          | invalid_raised, exception_request               |
//
// One word per cycle unless an output stall holds it back; two register stages
// (input register, then result register), the result is presented from the latter.
// Reset clears both valid flags only.
// An output stall holds the result; the input stage keeps accepting while the
// result stage is free or draining, so a released stall adds no bubble.
module fp_compare_condition_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  fpcc_pkg::operand_t operand_a_i,
  input  fpcc_pkg::operand_t operand_b_i,
  input  logic             is_double_i,
  input  fpcc_pkg::cond_t  condition_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             compare_bit_o,
  output logic             invalid_raised_o,
  output logic             exception_request_o
);
  import fpcc_pkg::*;

  logic     s1_valid_q;
  operand_t a_q, b_q;
  logic     dbl_q;
  cond_t    cond_q;
  logic     out_valid_q, bit_q, inv_q;
  logic     s2_load, s1_load;

  assign s2_load    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s2_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load || s2_load) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      a_q    <= operand_a_i;
      b_q    <= operand_b_i;
      dbl_q  <= is_double_i;
      cond_q <= condition_i;
    end
  end

  // classification
  operand_t   a_m, b_m, mag_a, mag_b;
  logic       sa, sb, nan_a, nan_b, nan, eq, lt, mag_lt, mag_gt;
  logic       bit_d, inv_d;
  cond_base_e base;

  always_comb begin
    if (dbl_q) begin
      a_m    = a_q;
      b_m    = b_q;
      sa     = a_q[63];
      sb     = b_q[63];
      mag_a  = {1'b0, a_q[62:0]};
      mag_b  = {1'b0, b_q[62:0]};
      nan_a  = (&a_q[62:52]) && (|a_q[51:0]);
      nan_b  = (&b_q[62:52]) && (|b_q[51:0]);
    end else begin
      a_m    = {32'd0, a_q[31:0]};
      b_m    = {32'd0, b_q[31:0]};
      sa     = a_q[31];
      sb     = b_q[31];
      mag_a  = {33'd0, a_q[30:0]};
      mag_b  = {33'd0, b_q[30:0]};
      nan_a  = (&a_q[30:23]) && (|a_q[22:0]);
      nan_b  = (&b_q[30:23]) && (|b_q[22:0]);
    end
    nan    = nan_a || nan_b;
    mag_lt = mag_a < mag_b;
    mag_gt = mag_b < mag_a;
    if (nan) begin
      eq = 1'b0;
      lt = 1'b0;
    end else if (mag_a == '0 && mag_b == '0) begin
      eq = 1'b1;
      lt = 1'b0;
    end else begin
      eq = (a_m == b_m);
      if (sa != sb)  lt = sa;
      else if (!sa)  lt = mag_lt;
      else           lt = mag_gt;
    end

    base  = cond_base_e'(cond_q[2:0]);
    inv_d = cond_q[3] && nan;
    case (base)
      COND_F:   bit_d = 1'b0;
      COND_UN:  bit_d = nan;
      COND_EQ:  bit_d = eq;
      COND_UEQ: bit_d = nan || eq;
      COND_OLT: bit_d = lt;
      COND_ULT: bit_d = nan || lt;
      COND_OLE: bit_d = lt || eq;
      COND_ULE: bit_d = nan || lt || eq;
      default:  bit_d = 1'b0;
    endcase
    if (inv_d) bit_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_load) begin
      bit_q <= bit_d;
      inv_q <= inv_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign compare_bit_o       = bit_q;
  assign invalid_raised_o    = inv_q;
  assign exception_request_o = inv_q;

endmodule

// ===== rtl/fpcc_checker.sv =====
// ----------------------------------------------------------------------------
// fpcc_checker
// Port-level checks for the FP compare-condition unit.
// ----------------------------------------------------------------------------
module fpcc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input logic compare_bit_o,
  input logic invalid_raised_o,
  input logic exception_request_o
);

  a_exc_eq_inv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (exception_request_o == invalid_raised_o))
    else $error("exception differs from invalid");

  a_inv_clears_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && invalid_raised_o) |-> !compare_bit_o)
    else $error("compare bit set with invalid");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(compare_bit_o)
      && $stable(invalid_raised_o))
    else $error("stalled result changed");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind fp_compare_condition_unit fpcc_checker u_fpcc_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives single and double compares through the FP compare-condition unit
// under random input gaps and output stalls, predicts each result word and
// checks it in order against the words that come out.
// ----------------------------------------------------------------------------
module tb_top;
  import fpcc_pkg::*;

  typedef struct packed {
    operand_t a;
    operand_t b;
    logic     dbl;
    cond_t    cond;
  } cmp_word_t;

  typedef struct packed {
    logic bit_v;
    logic inv;
    logic exc;
  } cc_word_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  operand_t operand_a_i = '0;
  operand_t operand_b_i = '0;
  logic     is_double_i = 1'b0;
  cond_t    condition_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  logic     compare_bit_o;
  logic     invalid_raised_o;
  logic     exception_request_o;

  cmp_word_t pending_q[$];
  cc_word_t  expected_q[$];
  int        errors = 0;
  int        n_checked = 0;
  int        n_nan = 0;
  int        send_idle_pct = 8;
  int        recv_idle_pct = 74;
  int        hold_cycles = 0;
  bit        pause_send = 1'b0;
  bit        stim_done = 1'b0;

  fp_compare_condition_unit DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic cc_word_t predict_cc(cmp_word_t w);
    operand_t  a, b, sm, em, fm, ma, mb;
    logic      nan, eq, lt, sa, sb;
    cc_word_t  r;
    a = w.a;
    b = w.b;
    if (w.dbl) begin
      sm = 64'h8000_0000_0000_0000;
      em = 64'h7FF0_0000_0000_0000;
      fm = 64'h000F_FFFF_FFFF_FFFF;
    end else begin
      a = {32'h0, a[31:0]};
      b = {32'h0, b[31:0]};
      sm = 64'h8000_0000;
      em = 64'h7F80_0000;
      fm = 64'h007F_FFFF;
    end
    nan = (((a & em) == em) && ((a & fm) != 0)) || (((b & em) == em) && ((b & fm) != 0));
    ma = a & ~sm;
    mb = b & ~sm;
    sa = (a & sm) != 0;
    sb = (b & sm) != 0;
    eq = 1'b0;
    lt = 1'b0;
    if (!nan) begin
      if (ma == 0 && mb == 0) eq = 1'b1;
      else begin
        eq = (a == b);
        if (sa != sb) lt = sa;
        else if (!sa) lt = ma < mb;
        else lt = ma > mb;
      end
    end
    r = '0;
    if (w.cond[3] && nan) begin
      r.inv = 1'b1;
      r.exc = 1'b1;
    end else begin
      case (cond_base_e'(w.cond[2:0]))
        COND_F:   r.bit_v = 1'b0;
        COND_UN:  r.bit_v = nan;
        COND_EQ:  r.bit_v = eq;
        COND_UEQ: r.bit_v = nan || eq;
        COND_OLT: r.bit_v = lt;
        COND_ULT: r.bit_v = nan || lt;
        COND_OLE: r.bit_v = lt || eq;
        default:  r.bit_v = nan || lt || eq;
      endcase
    end
    return r;
  endfunction

  // operand generator: mixes specials, near-equal pairs and raw noise
  function automatic operand_t pick_val(logic dbl, operand_t other);
    operand_t v;
    logic     s;
    s = 1'($urandom_range(0, 1));
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: v = dbl ? {s, 63'h0} : {v[63:32], s, 31'h0};
      1: v = dbl ? {s, 11'h7FF, 52'h0} : {v[63:32], s, 8'hFF, 23'h0};
      2: v = dbl ? {s, 11'h7FF, v[51:0] | 52'h1} : {v[63:32], s, 8'hFF, v[22:0] | 23'h1};
      3: v = dbl ? {s, 11'h0, v[51:0]} : {v[63:32], s, 8'h0, v[22:0]};
      4: v = other;
      5: v = other ^ (64'h1 << $urandom_range(0, dbl ? 63 : 31));
      6: v = other + 64'd1;
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_word(operand_t a, operand_t b, logic dbl, cond_t c);
    pending_q.push_back('{a, b, dbl, c});
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(posedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict_cc('{operand_a_i, operand_b_i, is_double_i, condition_i}));
        void'(pending_q.pop_front());
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (pending_q.size() > 0 && !pause_send &&
            ($urandom_range(0, 99) >= send_idle_pct)) begin
          in_valid_i  <= 1'b1;
          operand_a_i <= pending_q[0].a;
          operand_b_i <= pending_q[0].b;
          is_double_i <= pending_q[0].dbl;
          condition_i <= pending_q[0].cond;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // driver pops only on acceptance; front entry is what is on the pins
  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    cc_word_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word bit=%b inv=%b exc=%b", $time,
                   compare_bit_o, invalid_raised_o, exception_request_o);
        end else begin
          e = expected_q.pop_front();
          n_checked++;
          if (e.inv) n_nan++;
          if ({compare_bit_o, invalid_raised_o, exception_request_o} != e) begin
            errors++;
            $display("%0t: mismatch exp bit/inv/exc=%b%b%b got=%b%b%b", $time,
                     e.bit_v, e.inv, e.exc,
                     compare_bit_o, invalid_raised_o, exception_request_o);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    operand_t a, b;
    logic     d;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: each code on signed zeros and NaNs, then infinities and ordering
    for (int c = 0; c < 16; c++) begin
      add_word(64'h0, 64'h8000_0000, 1'b0, cond_t'(c));
      add_word(64'h7FF8_0000_0000_0000, 64'h3FF0_0000_0000_0000, 1'b1, cond_t'(c));
    end
    add_word(64'hFFFF_FFFF_7FC0_0000, 64'h0, 1'b0, cond_t'({1'b1, COND_ULE}));
    add_word(64'hABCD_0000_3F80_0000, 64'h1234_0000_3F80_0000, 1'b0, cond_t'(COND_EQ));
    add_word(64'hFFF0_0000_0000_0000, 64'h7FF0_0000_0000_0000, 1'b1, cond_t'(COND_OLT));
    add_word(64'hFF80_0001, 64'h0, 1'b0, cond_t'(COND_UN));
    add_word(64'h8000_0000_0000_0001, 64'h8000_0000_0000_0002, 1'b1, cond_t'(COND_OLT));
    add_word('1, '1, 1'b1, cond_t'({1'b1, COND_F}));
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 74 : 0;
      recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 8 : 0;
      for (int i = 0; i < 667; i++) begin
        d = 1'($urandom_range(0, 1));
        a = pick_val(d, {$urandom, $urandom});
        b = pick_val(d, a);
        if ($urandom_range(0, 1)) add_word(a, b, d, cond_t'($urandom_range(0, 15)));
        else add_word(b, a, d, cond_t'($urandom_range(0, 15)));
      end
      if (phase == 1) begin
        hold_cycles = 60;
        wait (hold_cycles == 0);
      end
      wait_drained();
      pause_send = 1'b1;
      repeat (5) @(posedge clk_i);
      pause_send = 1'b0;
    end
    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("tb_top: checked %0d compares, %0d signaling-NaN traps, over 3 pacing phases",
             n_checked, n_nan);
    if (errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
